### hw/rtl/isr_pkg.sv
// ----------------------------------------------------------------------------
// isr_pkg: shared types and constants for the integer square root core
// Holds the controller-to-datapath command bundle and fixed field widths.
// ----------------------------------------------------------------------------
package isr_pkg;

  // Width of the result root field.
  localparam int ROOT_WIDTH = 32;

  // Width of the configuration data bus.
  localparam int CFG_DATA_WIDTH = 32;

  // Width of the configuration byte address.
  localparam int CFG_ADDR_WIDTH = 3;

  // Register index of round_mode.
  localparam logic REG_ROUND_MODE = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture a new operand and clear the root.
    logic step;       // Resolve one root bit.
    logic round_fin;  // Apply rounding and register the result.
    logic neg_fin;    // Register the negative-input result.
  } isr_cmd_t;

endpackage

### hw/rtl/isr_datapath.sv
// ----------------------------------------------------------------------------
// isr_datapath: digit-by-digit square root datapath
// Holds operand, partial root and remainder, and the result registers.
// ----------------------------------------------------------------------------
module isr_datapath #(
  parameter int IN_WIDTH = 64,
  parameter int ITER     = 32
) (
  input  logic                          clk,
  input  logic [63:0]                   in_value,
  input  logic                          round_mode,
  input  isr_pkg::isr_cmd_t             cmd,
  output logic                          in_negative,
  output logic [isr_pkg::ROOT_WIDTH-1:0] out_root,
  output logic                          out_negative_error
);
  import isr_pkg::*;

  localparam int OP_W = 2 * ITER;

  logic [OP_W-1:0]       op_r, op_nxt;
  logic [ITER-1:0]       root_r, root_nxt;
  logic [ITER:0]         rem_r, rem_nxt;
  logic [ITER+1:0]       rem_shift;
  logic [ITER+1:0]       trial;
  logic [ITER+1:0]       diff;
  logic                  fits;
  logic                  round_up;
  logic [ITER:0]         root_rounded;
  logic [ROOT_WIDTH-1:0] res_root_r, res_root_nxt;
  logic                  res_err_r, res_err_nxt;

  // The sign is bit IN_WIDTH-1; higher input bits are ignored.
  assign in_negative = in_value[IN_WIDTH-1];

  // One restoring step: bring down two operand bits and try root*4+1.
  assign rem_shift = {rem_r[ITER-1:0], op_r[OP_W-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign diff      = rem_shift - trial;
  assign fits      = (rem_shift >= trial);

  // Nearest rounding: the next root is closer exactly when the remainder exceeds r.
  assign round_up     = round_mode && (rem_r > {1'b0, root_r});
  assign root_rounded = {1'b0, root_r} + {{ITER{1'b0}}, round_up};

  // Next-state logic for the iteration registers.
  always_comb begin
    op_nxt   = op_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    if (cmd.load) begin
      op_nxt   = OP_W'(in_value[IN_WIDTH-1:0]);
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (cmd.step) begin
      op_nxt   = {op_r[OP_W-3:0], 2'b00};
      root_nxt = {root_r[ITER-2:0], fits};
      rem_nxt  = fits ? diff[ITER:0] : rem_shift[ITER:0];
    end
  end

  // Next-state logic for the result registers.
  always_comb begin
    res_root_nxt = res_root_r;
    res_err_nxt  = res_err_r;
    if (cmd.neg_fin) begin
      res_root_nxt = '0;
      res_err_nxt  = 1'b1;
    end else if (cmd.round_fin) begin
      res_root_nxt = ROOT_WIDTH'(root_rounded);
      res_err_nxt  = 1'b0;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    root_r     <= root_nxt;
    rem_r      <= rem_nxt;
    res_root_r <= res_root_nxt;
    res_err_r  <= res_err_nxt;
  end

  assign out_root           = res_root_r;
  assign out_negative_error = res_err_r;

endmodule

### hw/rtl/isr_ctrl.sv
// ----------------------------------------------------------------------------
// isr_ctrl: sequencing controller for the integer square root core
// Steps the datapath through the root iterations and strobes the result.
// ----------------------------------------------------------------------------
module isr_ctrl #(
  parameter int ITER = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_negative,
  output logic              busy,
  output logic              out_valid,
  output isr_pkg::isr_cmd_t cmd
);
  import isr_pkg::*;

  localparam int CNT_W = $clog2(ITER);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             valid_r, valid_nxt;
  logic             accept;
  logic             last_step;

  assign accept    = start && !busy;
  assign last_step = (cnt_r == CNT_W'(ITER - 1));

  // State transitions and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_negative) begin
            cmd.neg_fin = 1'b1;
            valid_nxt   = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_step) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_fin = 1'b1;
        valid_nxt     = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

`ifndef SYNTHESIS
  // A result strobe follows only the rounding state or a negative transfer.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_ROUND || (accept && in_negative)))
    else $error("result strobe without a finishing cycle");

  // A non-negative transfer starts the iteration.
  a_start_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_negative |=> state_r == ST_CALC && cnt_r == '0)
    else $error("accepted operand did not start iterating");

  // The last iteration leads to rounding.
  a_calc_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC && last_step |=> state_r == ST_ROUND)
    else $error("iteration count overran");

  // Rounding produces exactly one strobe and frees the core.
  a_round_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |=> out_valid && !busy)
    else $error("rounding did not deliver a result");
`endif

endmodule

### hw/rtl/integer_square_root_core.sv
// ----------------------------------------------------------------------------
// integer_square_root_core: integer square root of a signed operand
// Floor or nearest root selected by the round_mode register.
// ----------------------------------------------------------------------------
// An operand is taken when start is high and busy is low. A non-negative
// operand goes through (IN_WIDTH+1)/2 iterations of the shared digit-by-digit
// step, one root bit each, and then through the rounding state. The result is
// strobed on out_valid in the cycle after rounding, and busy falls at the same
// time, so a new operand may be started while the result is shown.
// A negative operand is answered in the next cycle with root 0 and
// out_negative_error set. Results are shown for one cycle only; the receiver
// must take them then. round_mode sits at byte address 0 of the APB port and
// may be written only while the core is idle.
module integer_square_root_core #(
  parameter int IN_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [63:0]                        in_value,
  output logic                               out_valid,
  output logic [isr_pkg::ROOT_WIDTH-1:0]     out_root,
  output logic                               out_negative_error,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [isr_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [isr_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic [isr_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import isr_pkg::*;

  localparam int ITER = (IN_WIDTH + 1) / 2;

  isr_cmd_t cmd;
  logic     in_negative;
  logic     round_mode_r, round_mode_nxt;
  logic     reg_sel;

  // Register decode: word address bit selects the register index.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_WIDTH-1] == REG_ROUND_MODE);

  always_comb begin
    round_mode_nxt = round_mode_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      round_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_mode_r <= 1'b0;
    end else begin
      round_mode_r <= round_mode_nxt;
    end
  end

  // Read back the selected register.
  assign prdata = reg_sel ? {{(CFG_DATA_WIDTH-1){1'b0}}, round_mode_r} : '0;

  isr_ctrl #(
    .ITER (ITER)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_negative (in_negative),
    .busy        (busy),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  isr_datapath #(
    .IN_WIDTH (IN_WIDTH),
    .ITER     (ITER)
  ) u_datapath (
    .clk                (clk),
    .in_value           (in_value),
    .round_mode         (round_mode_r),
    .cmd                (cmd),
    .in_negative        (in_negative),
    .out_root           (out_root),
    .out_negative_error (out_negative_error)
  );

endmodule
